FILE: design/sequential_keyed_list_defines.svh
// ----------------------------------------------------------------------------
// Sequential keyed list assertion macros
// Wraps concurrent checks so that synthesis sees nothing.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_KEYED_LIST_DEFINES_SVH
`define SEQUENTIAL_KEYED_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while in reset
`define SKL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequential_keyed_list: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define SKL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequential_keyed_list: next-cycle check failed");

`else

`define SKL_ASSERT_IMP(label, ante, cons)
`define SKL_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: design/skl_pkg.sv
// ----------------------------------------------------------------------------
// Sequential keyed list package
// Field widths, operation codes and the stored record type.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int KeyW     = 32;
  localparam int PayloadW = 64;
  localparam int PosW     = 11;
  localparam int OpW      = 3;

  // Default list capacity (1 to 2047)
  localparam int DefCapacity = 64;

  // Operation codes
  localparam logic [OpW-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OpW-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OpW-1:0] OP_INS_SORT = 3'd2;
  localparam logic [OpW-1:0] OP_REM_HEAD = 3'd3;
  localparam logic [OpW-1:0] OP_REM_TAIL = 3'd4;
  localparam logic [OpW-1:0] OP_REM_KEY  = 3'd5;
  localparam logic [OpW-1:0] OP_FIND_POS = 3'd6;
  localparam logic [OpW-1:0] OP_FIND_KEY = 3'd7;

  // One stored record
  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [PayloadW-1:0]    payload;
  } entry_t;

endpackage

FILE: design/sequential_keyed_list.sv
// ----------------------------------------------------------------------------
// Sequential keyed list
// Fixed-capacity contiguous list of keyed records with head, tail and sorted
// insert, head, tail and keyed removal, and lookup by position or key.
// ----------------------------------------------------------------------------
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, in_opcode, in_key,         | request in
//          | in_payload, in_position                        |
//  out     | out_valid, out_stall, out_ok, out_found_key,   | result out
//          | out_found_payload, out_entry_count,            |
//          | out_is_empty, out_is_full                      |
//
//  One request at a time; in_stall stays high from acceptance until the
//  result has been taken. Records live in a memory with one write port and
//  one registered read port, and each scan or shift step is a read, then a
//  compare or write back. Refused requests and tail removal are the shortest;
//  a sorted insert into a list one short of full is the longest (the scan up
//  to the slot plus the shift of the rest). rst_n clears the count and the
//  sequencer only and holds in_stall high; memory contents are undefined
//  until written. A stalled result holds.
//
`include "sequential_keyed_list_defines.svh"

module sequential_keyed_list #(
  parameter int CAPACITY = skl_pkg::DefCapacity
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [skl_pkg::OpW-1:0]           in_opcode,
  input  logic signed [skl_pkg::KeyW-1:0]   in_key,
  input  logic [skl_pkg::PayloadW-1:0]      in_payload,
  input  logic [skl_pkg::PosW-1:0]          in_position,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_ok,
  output logic signed [skl_pkg::KeyW-1:0]   out_found_key,
  output logic [skl_pkg::PayloadW-1:0]      out_found_payload,
  output logic [skl_pkg::PosW-1:0]          out_entry_count,
  output logic                              out_is_empty,
  output logic                              out_is_full
);
  import skl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SCAN_RD = 4'd1;
  localparam logic [3:0] ST_SCAN_EV = 4'd2;
  localparam logic [3:0] ST_UP_RD   = 4'd3;
  localparam logic [3:0] ST_UP_WR   = 4'd4;
  localparam logic [3:0] ST_WR      = 4'd5;
  localparam logic [3:0] ST_DN_RD   = 4'd6;
  localparam logic [3:0] ST_DN_WR   = 4'd7;
  localparam logic [3:0] ST_FETCH   = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                ok_r, ok_nxt;
  logic signed [KeyW-1:0] fk_r, fk_nxt;
  logic [PayloadW-1:0] fp_r, fp_nxt;
  logic [OpW-1:0]      op_r;
  logic signed [KeyW-1:0] key_r;
  logic [PayloadW-1:0] payload_r;

  entry_t              mem [CAPACITY];
  entry_t              rd_data_r;
  logic [AW-1:0]       mem_ra;
  logic [AW-1:0]       mem_wa;
  entry_t              mem_wd;
  logic                mem_we;

  logic                in_acc;
  logic                out_acc;
  logic                is_full;
  logic                is_empty;
  logic                pos_ok;
  logic [PosW-1:0]     pos_m1;
  logic [CW-1:0]       ptr_m1;
  logic [CW-1:0]       ptr_p1;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign pos_m1   = in_position - PosW'(1);
  assign pos_ok   = (in_position != '0) && (in_position <= PosW'(count_r));
  assign ptr_m1   = ptr_r - CW'(1);
  assign ptr_p1   = ptr_r + CW'(1);

  // Handshake and result ports
  assign in_stall          = (state_r != ST_IDLE) || !rst_n;
  assign out_valid         = (state_r == ST_DONE);
  assign out_ok            = ok_r;
  assign out_found_key     = fk_r;
  assign out_found_payload = fp_r;
  assign out_entry_count   = PosW'(count_r);
  assign out_is_empty      = is_empty;
  assign out_is_full       = is_full;

  // Select the memory read address for the current step
  always_comb begin
    unique case (state_r)
      ST_IDLE:  mem_ra = pos_m1[AW-1:0];
      ST_UP_RD: mem_ra = ptr_m1[AW-1:0];
      ST_DN_RD: mem_ra = ptr_p1[AW-1:0];
      default:  mem_ra = ptr_r[AW-1:0];
    endcase
  end

  // Write back shifted records or the new record
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r[AW-1:0];
    mem_wd = rd_data_r;
    unique case (state_r)
      ST_UP_WR: mem_we = 1'b1;
      ST_DN_WR: mem_we = 1'b1;
      ST_WR: begin
        mem_we         = 1'b1;
        mem_wa         = idx_r[AW-1:0];
        mem_wd.key     = key_r;
        mem_wd.payload = payload_r;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Sequencer: scan, shift and finish one request
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    idx_nxt   = idx_r;
    ok_nxt    = ok_r;
    fk_nxt    = fk_r;
    fp_nxt    = fp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ok_nxt    = 1'b0;
          fk_nxt    = '0;
          fp_nxt    = '0;
          ptr_nxt   = '0;
          state_nxt = ST_DONE;
          unique case (in_opcode)
            OP_INS_HEAD: begin
              if (!is_full) begin
                idx_nxt   = '0;
                ptr_nxt   = count_r;
                state_nxt = ST_UP_RD;
              end
            end
            OP_INS_TAIL: begin
              if (!is_full) begin
                idx_nxt   = count_r;
                state_nxt = ST_WR;
              end
            end
            OP_INS_SORT: begin
              if (!is_full) state_nxt = ST_SCAN_RD;
            end
            OP_REM_HEAD: begin
              if (!is_empty) begin
                ok_nxt    = 1'b1;
                state_nxt = ST_DN_RD;
              end
            end
            OP_REM_TAIL: begin
              if (!is_empty) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_FIND_POS: begin
              if (pos_ok) begin
                ok_nxt    = 1'b1;
                state_nxt = ST_FETCH;
              end
            end
            default: state_nxt = ST_SCAN_RD;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (ptr_r == count_r) begin
          // End of list: sorted insert goes at the tail, a key search misses
          if (op_r == OP_INS_SORT) begin
            idx_nxt   = ptr_r;
            state_nxt = ST_UP_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        if (op_r == OP_INS_SORT) begin
          if (rd_data_r.key < key_r) begin
            ptr_nxt   = ptr_p1;
            state_nxt = ST_SCAN_RD;
          end else begin
            idx_nxt   = ptr_r;
            ptr_nxt   = count_r;
            state_nxt = ST_UP_RD;
          end
        end else if (rd_data_r.key == key_r) begin
          ok_nxt = 1'b1;
          if (op_r == OP_REM_KEY) begin
            state_nxt = ST_DN_RD;
          end else begin
            fk_nxt    = rd_data_r.key;
            fp_nxt    = rd_data_r.payload;
            state_nxt = ST_DONE;
          end
        end else begin
          ptr_nxt   = ptr_p1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_UP_RD: begin
        if (ptr_r == idx_r) state_nxt = ST_WR;
        else                state_nxt = ST_UP_WR;
      end
      ST_UP_WR: begin
        ptr_nxt   = ptr_m1;
        state_nxt = ST_UP_RD;
      end
      ST_WR: begin
        ok_nxt    = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = ST_DONE;
      end
      ST_DN_RD: begin
        if (ptr_p1 >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DN_WR;
        end
      end
      ST_DN_WR: begin
        ptr_nxt   = ptr_p1;
        state_nxt = ST_DN_RD;
      end
      ST_FETCH: begin
        fk_nxt    = rd_data_r.key;
        fp_nxt    = rd_data_r.payload;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_acc) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working and result registers, request capture
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    idx_r <= idx_nxt;
    ok_r  <= ok_nxt;
    fk_r  <= fk_nxt;
    fp_r  <= fp_nxt;
    if (in_acc) begin
      op_r      <= in_opcode;
      key_r     <= in_key;
      payload_r <= in_payload;
    end
  end

  // Record store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

  // Checks
  `SKL_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(CAPACITY))
  `SKL_ASSERT_NXT(a_done_to_idle, out_acc, state_r == ST_IDLE)
  `SKL_ASSERT_IMP(a_miss_zero, out_valid && !out_ok, (fk_r == '0) && (fp_r == '0))
  `SKL_ASSERT_NXT(a_count_hold, out_valid && out_stall, $stable(count_r) && $stable(ok_r))

endmodule
